FILE: rtl/mrl_pkg.sv
package mrl_pkg;

    localparam int ID_W    = 32;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 5;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    // request codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELALL = 2'd2;
    localparam logic [OP_W-1:0] OP_IGNORE = 2'd3;

    // result event codes
    localparam logic [KIND_W-1:0] EV_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] EV_ADD     = 2'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

    // register word indexes
    localparam logic REG_LIMIT   = 1'b0;
    localparam logic REG_CURRENT = 1'b1;

    // commands broadcast along the row of cells
    typedef struct packed {
        logic shift_right;  // take the entry of the cell nearer the head
        logic shift_left;   // take the entry of the cell nearer the tail
        logic capture;      // register the key compare
    } t_cell_ctrl;

endpackage

FILE: rtl/mru_reference_list.sv
// Most-recently-used list of (id, database tag) references.
// Input channel: i_in_valid / o_in_stall carry one request beat (operation,
// graphic id, database tag). Output channel: o_out_valid / i_out_stall carry
// result beats; o_last marks the final beat of each request.
// The list lives in a row of LIST_CAPACITY cells, head in cell 0. An insert
// shifts the whole row one cell towards the tail; release-all shifts it
// towards the head, one entry out per cycle while the output is not stalled.
// Add, zero-id and ignored requests load their result from the execute
// state; a touch first registers the compare in every cell, then loads its
// result; a non-empty release-all first enters its drain state, then drains.
// One request is in flight at a time: o_in_stall is high from acceptance
// until the last result beat is loaded into the output register.
// A stalled output holds its beat and the sequencer waits for it; a new
// request is still accepted while the final beat of the last one waits.
// Reset empties the list, clears the current id and sets ref_limit to 8.
// APB: register 0 (byte 0) ref_limit, read/write; register 1 (byte 4) reads
// the current id. pready is always high.
module mru_reference_list
    import mrl_pkg::*;
#(
    parameter int LIST_CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_graphic_id,
    input  logic [TAG_W-1:0]  i_database_tag,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [KIND_W-1:0] o_event_kind,
    output logic [ID_W-1:0]   o_ref_id,
    output logic [TAG_W-1:0]  o_ref_tag,
    output logic              o_hit,
    output logic              o_overflow,
    output logic              o_last,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CAP  = LIST_CAPACITY;
    localparam int CW   = $clog2(CAP + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_TOUCH  = 3'd2;
    localparam logic [2:0] S_RELALL = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [ID_W-1:0]    r_cur, n_cur;
    logic [LIMIT_W-1:0] r_limit;

    // latched request
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_gid;
    logic [TAG_W-1:0]   r_tag;

    // output register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [ID_W-1:0]    r_rid;
    logic [TAG_W-1:0]   r_rtag;
    logic               r_hit, r_ovf, r_last;

    // row of cells
    t_cell_ctrl         cell_ctrl;
    logic [CAP-1:0]     cell_en;
    logic [CAP-1:0]     in_range;
    logic [CAP-1:0]     match;
    logic [ID_W-1:0]    w_id  [CAP];
    logic [TAG_W-1:0]   w_tag [CAP];
    logic [TAG_W-1:0]   head_tag;

    // selections over the row
    logic [CAP-1:0]     sfx;
    logic [TAG_W-1:0]   hit_tag;
    logic [ID_W-1:0]    tail_id;
    logic [TAG_W-1:0]   tail_tag;

    // sequencer outputs
    logic               emit;
    logic [KIND_W-1:0]  e_kind;
    logic [ID_W-1:0]    e_id;
    logic [TAG_W-1:0]   e_tag;
    logic               e_hit, e_ovf, e_last;

    logic               accept, can_emit, full, over_limit, cfg_wr;
    logic [CW-1:0]      ins_count;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    // the output slot is free now or empties at this edge
    assign can_emit   = !r_out_valid || !i_out_stall;

    assign full       = (r_count == CW'(CAP));
    assign ins_count  = full ? r_count : r_count + CW'(1);
    assign over_limit = (CMPW'(ins_count) > CMPW'(r_limit));

    // ---- cells -------------------------------------------------------
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [ID_W-1:0]  prev_id, next_id;
        logic [TAG_W-1:0] prev_tag, next_tag;

        if (g == 0) begin : g_head
            assign prev_id  = r_gid;
            assign prev_tag = head_tag;
        end else begin : g_mid
            assign prev_id  = w_id[g-1];
            assign prev_tag = w_tag[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign next_id  = '0;
            assign next_tag = '0;
        end else begin : g_body
            assign next_id  = w_id[g+1];
            assign next_tag = w_tag[g+1];
        end

        assign in_range[g] = (CW'(g) < r_count);

        mrl_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_en       (cell_en[g]),
            .i_prev_id  (prev_id),
            .i_prev_tag (prev_tag),
            .i_next_id  (next_id),
            .i_next_tag (next_tag),
            .i_key      (r_gid),
            .i_in_range (in_range[g]),
            .o_id       (w_id[g]),
            .o_tag      (w_tag[g]),
            .o_match    (match[g])
        );
    end

    // Oldest match wins: pick the highest matching cell; every cell at or
    // below it moves one place towards the tail.
    always_comb begin
        logic acc;
        acc     = 1'b0;
        hit_tag = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (match[i] && !acc) begin
                hit_tag = hit_tag | w_tag[i];
            end
            acc    = acc | match[i];
            sfx[i] = acc;
        end
    end

    // tail entry, cell count-1
    always_comb begin
        tail_id  = '0;
        tail_tag = '0;
        for (int i = 0; i < CAP; i++) begin
            if (CW'(i) == r_count - CW'(1)) begin
                tail_id  = tail_id | w_id[i];
                tail_tag = tail_tag | w_tag[i];
            end
        end
    end

    // ---- sequencer ---------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cur     = r_cur;
        cell_ctrl = '0;
        cell_en   = '0;
        head_tag  = r_tag;
        emit      = 1'b0;
        e_kind    = EV_ACK;
        e_id      = '0;
        e_tag     = '0;
        e_hit     = 1'b0;
        e_ovf     = 1'b0;
        e_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_op)
                    OP_ADD: begin
                        if (can_emit) begin
                            emit  = 1'b1;
                            n_cur = r_gid;
                            if (r_gid != '0) begin
                                // insert at the head, report the add
                                cell_ctrl.shift_right = 1'b1;
                                cell_en = '1;
                                n_count = ins_count;
                                e_kind  = EV_ADD;
                                e_id    = r_gid;
                                e_tag   = r_tag;
                                e_ovf   = full;
                                e_last  = !over_limit;
                                n_state = over_limit ? S_TAIL : S_IDLE;
                            end else begin
                                e_last  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end

                    OP_TOUCH: begin
                        n_cur = r_gid;
                        if (r_gid != '0) begin
                            cell_ctrl.capture = 1'b1;
                            n_state = S_TOUCH;
                        end else if (can_emit) begin
                            emit    = 1'b1;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end

                    OP_RELALL: begin
                        if (r_count != '0) begin
                            n_state = S_RELALL;
                        end else if (can_emit) begin
                            emit    = 1'b1;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end

                    OP_IGNORE: begin
                        if (can_emit) begin
                            emit    = 1'b1;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            S_TOUCH: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    cell_ctrl.shift_right = 1'b1;
                    if (|match) begin
                        // move the hit to the head, keeping its stored tag
                        cell_en  = sfx;
                        head_tag = hit_tag;
                        e_hit    = 1'b1;
                    end else begin
                        cell_en = '1;
                        n_count = ins_count;
                        e_ovf   = full;
                    end
                    n_state = S_IDLE;
                end
            end

            S_RELALL: begin
                if (can_emit) begin
                    // drain from the head, one entry a beat
                    emit   = 1'b1;
                    e_kind = EV_RELEASE;
                    e_id   = w_id[0];
                    e_tag  = w_tag[0];
                    e_last = (r_count == CW'(1));
                    cell_ctrl.shift_left = 1'b1;
                    n_count = r_count - CW'(1);
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_TAIL: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_kind  = EV_RELEASE;
                    e_id    = tail_id;
                    e_tag   = tail_tag;
                    e_last  = 1'b1;
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- registers ---------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
            if (cfg_wr && (paddr[2] == REG_LIMIT)) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_gid <= i_graphic_id;
            r_tag <= i_database_tag;
        end
        if (emit) begin
            r_kind <= e_kind;
            r_rid  <= e_id;
            r_rtag <= e_tag;
            r_hit  <= e_hit;
            r_ovf  <= e_ovf;
            r_last <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_ref_id     = r_rid;
    assign o_ref_tag    = r_rtag;
    assign o_hit        = r_hit;
    assign o_overflow   = r_ovf;
    assign o_last       = r_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CURRENT) ? r_cur : {{(32 - LIMIT_W){1'b0}}, r_limit};

endmodule

FILE: rtl/mrl_cell.sv
module mrl_cell
    import mrl_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_en,
    input  logic [ID_W-1:0]  i_prev_id,
    input  logic [TAG_W-1:0] i_prev_tag,
    input  logic [ID_W-1:0]  i_next_id,
    input  logic [TAG_W-1:0] i_next_tag,
    input  logic [ID_W-1:0]  i_key,
    input  logic             i_in_range,
    output logic [ID_W-1:0]  o_id,
    output logic [TAG_W-1:0] o_tag,
    output logic             o_match
);

    logic [ID_W-1:0]  r_id;
    logic [TAG_W-1:0] r_tag;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_right && i_en) begin
            r_id  <= i_prev_id;
            r_tag <= i_prev_tag;
        end else if (i_ctrl.shift_left) begin
            r_id  <= i_next_id;
            r_tag <= i_next_tag;
        end
        // only entries inside the list may match
        if (i_ctrl.capture) begin
            r_match <= i_in_range && (r_id == i_key);
        end
    end

    assign o_id    = r_id;
    assign o_tag   = r_tag;
    assign o_match = r_match;

endmodule

FILE: test/mrl_tb_pkg.sv
package mrl_tb_pkg;

    import mrl_pkg::*;

    localparam int LIST_DEPTH = 16;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic              hit;
        logic              overflow;
        logic              last;
    } t_ref_result;

    class ref_list_checker;

        logic [ID_W-1:0]  list_ids  [LIST_DEPTH];
        logic [TAG_W-1:0] list_tags [LIST_DEPTH];
        int               used;
        int               limit;
        logic [ID_W-1:0]  current_id;
        t_ref_result      awaited [$];
        int unsigned      fails;

        function new();
            used       = 0;
            limit      = int'(LIMIT_RESET);
            current_id = '0;
            fails      = 0;
        endfunction

        function void set_limit(int value);
            limit = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function t_ref_result make_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                          logic [TAG_W-1:0] tag, logic hit, logic overflow);
            t_ref_result r;
            r.kind     = kind;
            r.id       = id;
            r.tag      = tag;
            r.hit      = hit;
            r.overflow = overflow;
            r.last     = 1'b0;
            return r;
        endfunction

        // Insert at the head; a full list loses its tail without a release, flagged by the return value.
        function logic insert_head(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag);
            logic dropped;
            dropped = (used >= LIST_DEPTH);
            if (dropped) begin
                used = LIST_DEPTH - 1;
            end
            for (int i = used; i > 0; i--) begin
                list_ids[i]  = list_ids[i-1];
                list_tags[i] = list_tags[i-1];
            end
            list_ids[0]  = id;
            list_tags[0] = tag;
            used++;
            return dropped;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [TAG_W-1:0] tag);
            t_ref_result      burst [$];
            t_ref_result      tail;
            logic             hit;
            logic             dropped;
            logic [TAG_W-1:0] kept;
            hit     = 1'b0;
            dropped = 1'b0;
            case (op)
                OP_ADD: begin
                    if (id != '0) begin
                        dropped = insert_head(id, tag);
                        burst.push_back(make_result(EV_ADD, id, tag, 1'b0, dropped));
                        // one release per add, even if a lowered limit leaves it long
                        if (used > limit) begin
                            used--;
                            burst.push_back(make_result(EV_RELEASE, list_ids[used],
                                                        list_tags[used], 1'b0, 1'b0));
                        end
                    end else begin
                        burst.push_back(make_result(EV_ACK, '0, '0, 1'b0, 1'b0));
                    end
                    current_id = id;
                end
                OP_TOUCH: begin
                    if (id != '0) begin
                        // search from the tail: the oldest match wins
                        for (int i = used - 1; i >= 0 && !hit; i--) begin
                            if (list_ids[i] == id) begin
                                kept = list_tags[i];
                                for (int j = i; j > 0; j--) begin
                                    list_ids[j]  = list_ids[j-1];
                                    list_tags[j] = list_tags[j-1];
                                end
                                list_ids[0]  = id;
                                list_tags[0] = kept;
                                hit          = 1'b1;
                            end
                        end
                        if (!hit) begin
                            dropped = insert_head(id, tag);
                        end
                    end
                    burst.push_back(make_result(EV_ACK, '0, '0, hit, dropped));
                    current_id = id;
                end
                OP_RELALL: begin
                    for (int i = 0; i < used; i++) begin
                        burst.push_back(make_result(EV_RELEASE, list_ids[i], list_tags[i],
                                                    1'b0, 1'b0));
                    end
                    if (used == 0) begin
                        burst.push_back(make_result(EV_ACK, '0, '0, 1'b0, 1'b0));
                    end
                    used = 0;
                end
                default: begin
                    burst.push_back(make_result(EV_ACK, '0, '0, 1'b0, 1'b0));
                end
            endcase
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
            foreach (burst[i]) begin
                awaited.push_back(burst[i]);
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                   logic [TAG_W-1:0] tag, logic hit, logic overflow,
                                   logic last);
            t_ref_result want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: kind %0d id 0x%0h", kind, id);
                fails++;
                return;
            end
            want = awaited.pop_front();
            compare("event_kind", 32'(want.kind), 32'(kind));
            compare("ref_id", want.id, id);
            compare("ref_tag", 32'(want.tag), 32'(tag));
            compare("hit", 32'(want.hit), 32'(hit));
            compare("overflow", 32'(want.overflow), 32'(overflow));
            compare("last", 32'(want.last), 32'(last));
        endfunction

    endclass

endpackage

FILE: test/tb_top.sv
module tb_top
    import mrl_pkg::*;
    import mrl_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Request side and result side run as separate processes. The request
    // process walks through the phases; the result process checks every beat
    // against the oldest awaited result and throws its own stall dice.

    localparam int ID_POOL        = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_operation    = OP_IGNORE;
    logic [ID_W-1:0]   i_graphic_id   = '0;
    logic [TAG_W-1:0]  i_database_tag = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [KIND_W-1:0] o_event_kind;
    logic [ID_W-1:0]   o_ref_id;
    logic [TAG_W-1:0]  o_ref_tag;
    logic              o_hit;
    logic              o_overflow;
    logic              o_last;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [2:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic [31:0]       prdata;
    logic              pready;

    ref_list_checker   board;
    int unsigned       idle_pct       = 32;
    int unsigned       quiet_cycles   = 0;
    logic [ID_W-1:0]   id_pool [ID_POOL];

    mru_reference_list #(.LIST_CAPACITY(LIST_DEPTH)) i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check the beat taken at this edge, then roll the stall
    // for the next cycle. Hold the stall low while in reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_event_kind, o_ref_id, o_ref_tag, o_hit, o_overflow,
                                   o_last);
            end
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Watchdog: any beat on either channel or the register port restarts the
    // count; a long silence means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request beat, after a random run of idle cycles, and hold it
    // until the block takes it. Return just after the accepting edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_graphic_id   <= id;
        i_database_tag <= tag;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        board.note_request(op, id, tag);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [2:0] addr, input logic [31:0] want,
                                  input string name);
        logic [31:0] got;
        apb_read(addr, got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            board.fails++;
        end
    endtask

    task automatic set_limit(input int value);
        apb_write({REG_LIMIT, 2'b00}, 32'(value));
        board.set_limit(value);
        check_register({REG_LIMIT, 2'b00}, 32'(value), "ref_limit");
    endtask

    // Drop valid, drain every awaited result, let the block go quiet, then
    // read back the current id.
    task automatic end_phase();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        check_register({REG_CURRENT, 2'b00}, board.current_id, "current_id");
    endtask

    // Mostly ids from a small pool so touches hit and duplicates pile up;
    // some fresh random ids and the odd zero id.
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 75) begin
            return id_pool[$urandom_range(ID_POOL - 1)];
        end
        return $urandom;
    endfunction

    // Random requests; ignored operations do not advance the count.
    task automatic run_phase(input int unsigned items, input int unsigned relall_pct);
        int unsigned     done;
        int unsigned     roll;
        logic [OP_W-1:0] op;
        done = 0;
        while (done < items) begin
            roll = $urandom_range(99);
            if (roll < relall_pct) begin
                op = OP_RELALL;
            end else if (roll < relall_pct + 3) begin
                op = OP_IGNORE;
            end else if (roll < 55) begin
                op = OP_ADD;
            end else begin
                op = OP_TOUCH;
            end
            send_request(op, pick_id(), 16'($urandom));
            if (op != OP_IGNORE) begin
                done++;
            end
        end
        end_phase();
    endtask

    initial begin
        board = new();
        foreach (id_pool[k]) begin
            id_pool[k] = (k < 4) ? ID_W'(k + 1) : ID_W'($urandom);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_register({REG_LIMIT, 2'b00}, 32'(LIMIT_RESET), "ref_limit");
        check_register({REG_CURRENT, 2'b00}, '0, "current_id");

        // Directed part at the reset limit of eight.
        // Zero id on add and on touch: acknowledge only, list untouched.
        send_request(OP_ADD, '0, 16'hFFFF);
        send_request(OP_TOUCH, '0, 16'h0000);
        // Release-all of an empty list, then the unused operation code.
        send_request(OP_RELALL, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_IGNORE, 32'hFFFF_FFFF, 16'hFFFF);
        // Field extremes, then a duplicate id so the touch must pick the oldest.
        send_request(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_ADD, 32'h0000_0001, 16'h0000);
        send_request(OP_ADD, 32'h8000_0000, 16'h8000);
        send_request(OP_ADD, 32'h0000_0001, 16'h1234);
        send_request(OP_TOUCH, 32'h0000_0001, 16'hABCD);
        // Touch miss: silent insert at the head.
        send_request(OP_TOUCH, 32'h5A5A_5A5A, 16'h5A5A);
        send_request(OP_RELALL, '0, '0);
        // Grow past the limit so the later adds release the tail.
        for (int k = 2; k < 12; k++) begin
            send_request(OP_ADD, ID_W'(k), TAG_W'(k * 4097));
        end
        send_request(OP_TOUCH, 32'h0000_0006, 16'h0000);
        send_request(OP_RELALL, '0, '0);
        end_phase();

        // Limit at capacity: the list fills, so adds and touch misses overflow.
        set_limit(16);
        run_phase(40, 2);
        // Lowered limit: each add over the limit releases one tail only.
        set_limit(2);
        run_phase(25, 5);
        // Long stretch with no idling on either side.
        idle_pct = 0;
        set_limit(0);
        run_phase(40, 8);
        idle_pct = 32;
        set_limit(1);
        run_phase(25, 8);
        set_limit(int'($urandom_range(16)));
        run_phase(30, 6);
        set_limit(15);
        run_phase(30, 3);

        // Catch stray beats after the last awaited result.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.fails == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
